FILE: sv/dkf_pkg.sv
`timescale 1ns / 1ps

package dkf_pkg;

    localparam int SEG_COUNT = 3;
    localparam logic [7:0] SEPARATOR = 8'd46;
    localparam logic [7:0] NUL_BYTE = 8'd0;
    localparam logic [8:0] MOD_FLETCHER = 9'd255;
    localparam logic [1:0] SEG_PAST = 2'd3;
    localparam logic [15:0] SUM_ZERO = 16'h0000;

    typedef struct packed {
        logic [7:0] key_byte;
        logic       is_final;
    } dkf_item_t;

    typedef struct packed {
        logic [15:0] first_sum;
        logic [15:0] second_sum;
        logic [15:0] third_sum;
    } dkf_result_t;

    // a is always below 255, so one conditional subtract is enough
    function automatic logic [7:0] mod255_add(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] sum;
        logic [8:0] red;
        begin
            sum = {1'b0, a} + {1'b0, b};
            red = (sum >= MOD_FLETCHER) ? (sum - MOD_FLETCHER) : sum;
            mod255_add = red[7:0];
        end
    endfunction

endpackage

FILE: sv/dkf_in_stage.sv
`timescale 1ns / 1ps

module dkf_in_stage
    import dkf_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  logic [7:0] s_key_byte,
    input  logic      s_is_final,
    input  logic      advance,
    output logic      item_valid,
    output dkf_item_t item
);

    logic      valid_reg;
    logic      valid_next;
    dkf_item_t item_reg;

    assign s_ready    = !valid_reg || advance;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg.key_byte <= s_key_byte;
            item_reg.is_final <= s_is_final;
        end
    end

endmodule

FILE: sv/dkf_seg_accum.sv
`timescale 1ns / 1ps

module dkf_seg_accum
    import dkf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        advance,
    input  dkf_item_t   item,
    output dkf_result_t result
);

    logic [7:0] low_reg  [SEG_COUNT];
    logic [7:0] high_reg [SEG_COUNT];
    logic [7:0] low_next [SEG_COUNT];
    logic [7:0] high_next[SEG_COUNT];
    logic [1:0] seg_idx_reg;
    logic [1:0] seg_idx_next;
    logic       frozen_reg;
    logic       frozen_next;
    logic [7:0] s1;

    always_comb begin
        for (int k = 0; k < SEG_COUNT; k++) begin
            low_next[k]  = low_reg[k];
            high_next[k] = high_reg[k];
        end
        seg_idx_next = seg_idx_reg;
        frozen_next  = frozen_reg;
        s1           = 8'd0;

        if (advance && (seg_idx_reg != SEG_PAST)) begin
            if (item.key_byte == SEPARATOR) begin
                seg_idx_next = seg_idx_reg + 2'd1;
                frozen_next  = 1'b0;
            end else if (!frozen_reg) begin
                if (item.key_byte == NUL_BYTE) begin
                    frozen_next = 1'b1;
                end else begin
                    for (int k = 0; k < SEG_COUNT; k++) begin
                        if (seg_idx_reg == 2'(k)) begin
                            s1           = mod255_add(low_reg[k], item.key_byte);
                            low_next[k]  = s1;
                            high_next[k] = mod255_add(high_reg[k], s1);
                        end
                    end
                end
            end
        end

        // checksums include the final byte itself
        result.first_sum  = {high_next[0], low_next[0]};
        result.second_sum = {high_next[1], low_next[1]};
        result.third_sum  = {high_next[2], low_next[2]};

        if (advance && item.is_final) begin
            for (int k = 0; k < SEG_COUNT; k++) begin
                low_next[k]  = 8'd0;
                high_next[k] = 8'd0;
            end
            seg_idx_next = 2'd0;
            frozen_next  = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < SEG_COUNT; k++) begin
                low_reg[k]  <= 8'd0;
                high_reg[k] <= 8'd0;
            end
            seg_idx_reg <= 2'd0;
            frozen_reg  <= 1'b0;
        end else begin
            for (int k = 0; k < SEG_COUNT; k++) begin
                low_reg[k]  <= low_next[k];
                high_reg[k] <= high_next[k];
            end
            seg_idx_reg <= seg_idx_next;
            frozen_reg  <= frozen_next;
        end
    end

endmodule

FILE: sv/dkf_out_reg.sv
`timescale 1ns / 1ps

module dkf_out_reg
    import dkf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        load,
    input  dkf_result_t result,
    output logic        load_ok,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_first_sum,
    output logic [15:0] m_second_sum,
    output logic [15:0] m_third_sum
);

    logic        valid_reg;
    logic        valid_next;
    dkf_result_t result_reg;

    assign load_ok      = !valid_reg || m_ready;
    assign m_valid      = valid_reg;
    assign m_first_sum  = result_reg.first_sum;
    assign m_second_sum = result_reg.second_sum;
    assign m_third_sum  = result_reg.third_sum;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= result;
        end
    end

endmodule

FILE: sv/dotted_key_fletcher16_hasher_unit.sv
`timescale 1ns / 1ps

// Dotted-key Fletcher-16 hasher.
// Input channel (s_valid / s_ready): one key byte per request, s_is_final
// marks the last byte of a key. A '.' separates segments; up to three
// segments each get a Fletcher-16 checksum (sum2 in the high byte, sum1 low).
// Result channel (m_valid / m_ready): one request per key carrying the three
// checksums; absent or empty segments read as zero.
// The final byte is registered in the input register at its accept edge;
// its result is loaded into the output register once load_ok allows it.
// Throughput: one byte per cycle while s_ready is high, set by the mod-255
// updates of sum1 and sum2 between the input register and the sum registers.
// When the receiver stalls, the result is held in the output register while
// non-final bytes keep flowing; a second final byte waits in the input
// register, and s_ready drops only once both registers are full.
// Reset (aresetn low, synchronous) empties both registers and clears all
// running sums and the segment position.

module dotted_key_fletcher16_hasher_unit
    import dkf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_key_byte,
    input  logic        s_is_final,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_first_sum,
    output logic [15:0] m_second_sum,
    output logic [15:0] m_third_sum
);

    logic        item_valid;
    dkf_item_t   item;
    logic        advance;
    logic        load_ok;
    dkf_result_t result;

    // non-final bytes never need the output register
    assign advance = item_valid && (!item.is_final || load_ok);

    dkf_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_key_byte (s_key_byte),
        .s_is_final (s_is_final),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    dkf_seg_accum u_seg_accum (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .item    (item),
        .result  (result)
    );

    dkf_out_reg u_out_reg (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .load         (advance && item.is_final),
        .result       (result),
        .load_ok      (load_ok),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_first_sum  (m_first_sum),
        .m_second_sum (m_second_sum),
        .m_third_sum  (m_third_sum)
    );

endmodule
